FILE: hdl/cpsd_pkg.sv
`default_nettype none

package cpsd_pkg;

    localparam int unsigned CFG_W     = 24;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_SMOOTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_DUR    = 2'd2;

    localparam logic [CFG_W-1:0] SMOOTH_RST       = 24'd19661;
    localparam logic [CFG_W-1:0] BLEND_SMOOTH_RST = 24'd45875;
    localparam logic [CFG_W-1:0] BLEND_DUR_RST    = 24'd32768;
    localparam logic [CFG_W-1:0] MIN_SMOOTH       = 24'd7;

    localparam logic [63:0] COEF_SQ   = 64'd31457;
    localparam logic [63:0] COEF_CU   = 64'd15401;
    localparam logic [64:0] LENSQ_MIN = 65'd4295;
    localparam logic [24:0] X_CAP     = 25'h100_0000;
    localparam logic signed [63:0] SAT_CAP = 64'sh4000_0000_0000_0000;
    localparam logic signed [31:0] Q_ONE   = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] target_eye_x;
        logic signed [31:0] target_eye_y;
        logic signed [31:0] target_eye_z;
        logic signed [31:0] forward_x;
        logic signed [31:0] forward_y;
        logic signed [31:0] forward_z;
        logic               pose_valid;
        logic [7:0]         area_number;
        logic [15:0]        time_step;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] look_at_x;
        logic signed [31:0] look_at_y;
        logic signed [31:0] look_at_z;
    } t_out_word;

    // Clamp a wide sum to the intermediate range of plus or minus 2^62.
    function automatic logic signed [63:0] clamp62(input logic signed [64:0] v);
        logic signed [64:0] cap;
        cap = {SAT_CAP[63], SAT_CAP};
        if (v > cap) begin
            return SAT_CAP;
        end else if (v < -cap) begin
            return -SAT_CAP;
        end
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return clamp62({a[63], a} + {b[63], b});
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return clamp62({a[63], a} - {b[63], b});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7fff_ffff) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sh8000_0000) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [62:0] mag63(input logic signed [63:0] v);
        logic signed [63:0] m;
        m = (v < 0) ? -v : v;
        return m[62:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cpsd_if.sv
`default_nettype none

interface cpsd_in_if import cpsd_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpsd_out_if import cpsd_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/camera_pose_smooth_damp_core.sv
// A new word is taken only once the previous result stands in the output
// register. The shared 32x32 multiplier and the one-bit-a-cycle divider are
// used in turn.
// Reset (synchronous, active low) clears state and loads the register defaults.
`default_nettype none

module camera_pose_smooth_damp_core import cpsd_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data,
    cpsd_in_if.sink              i_in,
    cpsd_out_if.source           o_out
);

    typedef enum logic [4:0] {
        S_IDLE, S_LEN, S_LENACC, S_SEL, S_AT, S_DIV, S_OMEGA,
        S_XM, S_X, S_X2M, S_X2, S_X3M, S_X3, S_D1M, S_D1, S_D2M, S_D2, S_E,
        S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8, S_A9, S_A10,
        S_MUL, S_OUT
    } t_state;

    t_state r_state, r_mret, r_dret;

    logic [CFG_W-1:0] r_smooth, r_blend_smooth, r_blend_dur;

    logic signed [31:0] r_pos [6];
    logic signed [31:0] r_vel [6];
    logic signed [31:0] r_tgt [6];
    logic signed [31:0] r_fwd [3];
    logic               r_started;
    logic [8:0]         r_prev_area;
    logic [24:0]        r_timer;

    logic               r_pvalid;
    logic [7:0]         r_area;
    logic [15:0]        r_dt;
    logic [64:0]        r_lensq;
    logic [1:0]         r_k;
    logic [2:0]         r_ax;

    logic [30:0] r_omega;
    logic [24:0] r_x;
    logic [32:0] r_x2;
    logic [40:0] r_x3;
    logic [55:0] r_d;
    logic [16:0] r_e;

    logic signed [63:0] r_chg, r_t, r_tmp;
    logic signed [31:0] r_nv;

    // Shared multiplier.
    logic [62:0]  r_ma, r_mb;
    logic         r_mneg;
    logic [1:0]   r_mcnt;
    logic [127:0] r_prod;

    // Shared restoring divider.
    logic [33:0] r_dnum, r_dquo;
    logic [55:0] r_dden, r_drem;
    logic [5:0]  r_dcnt;

    logic        r_ovalid;
    t_out_word   r_out;

    logic               mul_start;
    logic signed [63:0] mul_a, mul_b;
    logic [31:0]        a_part, b_part;
    logic [63:0]        pp;
    logic [127:0]       pp_sh;
    logic [63:0]        mq_mag;
    logic signed [63:0] mq;
    logic [56:0]        rem_sh;
    logic               rem_ge;
    logic signed [63:0] pos_x, vel_x, tgt_x;
    logic signed [31:0] at_v [3];
    logic               fallback;
    logic [CFG_W-1:0]   st_sel;
    logic [24:0]        timer_ld;
    logic [55:0]        den_e;

    always_comb begin
        mul_start = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            S_LEN: begin
                mul_a = {{32{r_fwd[r_k][31]}}, r_fwd[r_k]};
                mul_b = {{32{r_fwd[r_k][31]}}, r_fwd[r_k]};
            end
            S_XM:  begin mul_a = {33'd0, r_omega}; mul_b = {48'd0, r_dt}; end
            S_X2M: begin mul_a = {39'd0, r_x};     mul_b = {39'd0, r_x};  end
            S_X3M: begin mul_a = {31'd0, r_x2};    mul_b = {39'd0, r_x};  end
            S_D1M: begin mul_a = COEF_SQ;          mul_b = {31'd0, r_x2}; end
            S_D2M: begin mul_a = COEF_CU;          mul_b = {23'd0, r_x3}; end
            S_A1:  begin mul_a = r_chg; mul_b = {33'd0, r_omega}; end
            S_A3:  begin mul_a = r_t;   mul_b = {48'd0, r_dt};    end
            S_A5:  begin mul_a = r_tmp; mul_b = {33'd0, r_omega}; end
            S_A7:  begin mul_a = r_t;   mul_b = {47'd0, r_e};     end
            S_A9:  begin mul_a = r_t;   mul_b = {47'd0, r_e};     end
            default: mul_start = 1'b0;
        endcase
    end

    always_comb begin
        a_part = r_mcnt[1] ? {1'b0, r_ma[62:32]} : r_ma[31:0];
        b_part = r_mcnt[0] ? {1'b0, r_mb[62:32]} : r_mb[31:0];
        pp     = 64'(a_part) * 64'(b_part);
        case (r_mcnt)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        // Anything at or above 2^78 saturates; below it the shifted value is under 2^62.
        mq_mag = (|r_prod[127:78]) ? SAT_CAP : {2'b00, r_prod[77:16]};
        mq     = r_mneg ? -$signed(mq_mag) : $signed(mq_mag);
    end

    always_comb begin
        rem_sh = {r_drem, r_dnum[33]};
        rem_ge = (rem_sh >= {1'b0, r_dden});
    end

    always_comb begin
        pos_x    = {{32{r_pos[r_ax][31]}}, r_pos[r_ax]};
        vel_x    = {{32{r_vel[r_ax][31]}}, r_vel[r_ax]};
        tgt_x    = {{32{r_tgt[r_ax][31]}}, r_tgt[r_ax]};
        fallback = !r_pvalid || (r_lensq < LENSQ_MIN);
        for (int i = 0; i < 3; i++) begin
            at_v[i] = sat32(64'(r_tgt[i]) + 64'(r_fwd[i]));
        end
        timer_ld = ({1'b0, r_area} != r_prev_area) ? {1'b0, r_blend_dur} : r_timer;
        st_sel   = (timer_ld != '0) ? r_blend_smooth : r_smooth;
        if (st_sel < MIN_SMOOTH) begin
            st_sel = MIN_SMOOTH;
        end
        den_e = r_d + mq[55:0];
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_started      <= 1'b0;
            r_prev_area    <= 9'd511;
            r_timer        <= '0;
            r_ovalid       <= 1'b0;
            r_smooth       <= SMOOTH_RST;
            r_blend_smooth <= BLEND_SMOOTH_RST;
            r_blend_dur    <= BLEND_DUR_RST;
            for (int i = 0; i < 6; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SMOOTH:       r_smooth       <= i_cfg_data;
                    CFG_BLEND_SMOOTH: r_blend_smooth <= i_cfg_data;
                    CFG_BLEND_DUR:    r_blend_dur    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            if (mul_start) begin
                r_ma    <= mag63(mul_a);
                r_mb    <= mag63(mul_b);
                r_mneg  <= (mul_a < 0) != (mul_b < 0);
                r_mcnt  <= '0;
                r_prod  <= '0;
                r_mret  <= t_state'(r_state + 5'd1);
                r_state <= S_MUL;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_tgt[0] <= i_in.data.target_eye_x;
                        r_tgt[1] <= i_in.data.target_eye_y;
                        r_tgt[2] <= i_in.data.target_eye_z;
                        r_fwd[0] <= i_in.data.forward_x;
                        r_fwd[1] <= i_in.data.forward_y;
                        r_fwd[2] <= i_in.data.forward_z;
                        r_pvalid <= i_in.data.pose_valid;
                        r_area   <= i_in.data.area_number;
                        r_dt     <= i_in.data.time_step;
                        r_lensq  <= '0;
                        r_k      <= '0;
                        r_state  <= S_LEN;
                    end
                end
                S_MUL: begin
                    r_prod <= r_prod + pp_sh;
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd3) begin
                        r_state <= r_mret;
                    end
                end
                S_DIV: begin
                    r_drem <= rem_ge ? 56'(rem_sh - {1'b0, r_dden}) : rem_sh[55:0];
                    r_dquo <= {r_dquo[32:0], rem_ge};
                    r_dnum <= {r_dnum[32:0], 1'b0};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd33) begin
                        r_state <= r_dret;
                    end
                end
                S_LENACC: begin
                    r_lensq <= r_lensq + {1'b0, r_prod[63:0]};
                    r_k     <= r_k + 2'd1;
                    r_state <= (r_k == 2'd2) ? S_SEL : S_LEN;
                end
                S_SEL: begin
                    if (fallback) begin
                        if (r_started) begin
                            for (int i = 0; i < 3; i++) begin
                                r_tgt[i] <= r_pos[i];
                            end
                        end else begin
                            r_tgt[0] <= '0;
                            r_tgt[1] <= 3 * Q_ONE;
                            r_tgt[2] <= -10 * Q_ONE;
                        end
                        r_fwd[0] <= '0;
                        r_fwd[1] <= '0;
                        r_fwd[2] <= Q_ONE;
                        for (int i = 0; i < 6; i++) begin
                            r_vel[i] <= '0;
                        end
                    end
                    r_state <= S_AT;
                end
                S_AT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_tgt[3+i] <= at_v[i];
                        if (!r_started) begin
                            r_pos[i]   <= r_tgt[i];
                            r_pos[3+i] <= at_v[i];
                        end
                    end
                    r_started   <= 1'b1;
                    r_prev_area <= {1'b0, r_area};
                    r_timer     <= (timer_ld > 25'(r_dt)) ? 25'(timer_ld - 25'(r_dt)) : '0;
                    r_dnum      <= 34'h2_0000_0000;
                    r_dden      <= 56'(st_sel);
                    r_drem      <= '0;
                    r_dquo      <= '0;
                    r_dcnt      <= '0;
                    r_dret      <= S_OMEGA;
                    r_state     <= S_DIV;
                end
                S_OMEGA: begin
                    r_omega <= r_dquo[30:0];
                    r_state <= S_XM;
                end
                S_X: begin
                    r_x     <= (mq > $signed({39'd0, X_CAP})) ? X_CAP : mq[24:0];
                    r_state <= S_X2M;
                end
                S_X2: begin
                    r_x2    <= mq[32:0];
                    r_state <= S_X3M;
                end
                S_X3: begin
                    r_x3    <= mq[40:0];
                    r_state <= S_D1M;
                end
                S_D1: begin
                    r_d     <= 56'd65536 + 56'(r_x) + mq[55:0];
                    r_state <= S_D2M;
                end
                S_D2: begin
                    r_dnum  <= 34'h1_0000_0000;
                    r_dden  <= den_e;
                    r_drem  <= '0;
                    r_dquo  <= '0;
                    r_dcnt  <= '0;
                    r_dret  <= S_E;
                    r_state <= S_DIV;
                end
                S_E: begin
                    r_e     <= r_dquo[16:0];
                    r_ax    <= '0;
                    r_state <= S_A0;
                end
                S_A0: begin
                    r_chg   <= sat_sub(pos_x, tgt_x);
                    r_state <= S_A1;
                end
                S_A2: begin
                    r_t     <= sat_add(vel_x, mq);
                    r_state <= S_A3;
                end
                S_A4: begin
                    r_tmp   <= mq;
                    r_state <= S_A5;
                end
                S_A6: begin
                    r_t     <= sat_sub(vel_x, mq);
                    r_state <= S_A7;
                end
                S_A8: begin
                    r_nv    <= sat32(mq);
                    r_t     <= sat_add(r_chg, r_tmp);
                    r_state <= S_A9;
                end
                S_A10: begin
                    r_pos[r_ax] <= sat32(sat_add(tgt_x, mq));
                    r_vel[r_ax] <= r_nv;
                    if (r_ax == 3'd5) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ax    <= r_ax + 3'd1;
                        r_state <= S_A0;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_out.eye_x     <= r_pos[0];
                        r_out.eye_y     <= r_pos[1];
                        r_out.eye_z     <= r_pos[2];
                        r_out.look_at_x <= r_pos[3];
                        r_out.look_at_y <= r_pos[4];
                        r_out.look_at_z <= r_pos[5];
                        r_ovalid        <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a word is still in progress");

    a_mul_four_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_mcnt == 2'd3) |=> (r_state != S_MUL))
        else $error("multiplier ran past its last partial product");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_OUT))
        else $error("result word raised outside the output step");

    a_started_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_started)
        else $error("result word before the first word was seen");
`endif

endmodule

`default_nettype wire

FILE: bench/cpsd_tb_if.sv
`timescale 1ns / 1ps

// The channel interfaces come with the RTL; this file only carries the
// word generator used by the bench so that the top module stays readable.
package cpsd_tb_pkg;
    import cpsd_pkg::*;

    function automatic logic signed [31:0] rand_q(input int mode);
        logic signed [31:0] v;
        case (mode)
            0: v = 32'sh7fff_ffff;
            1: v = 32'sh8000_0000;
            2: v = 32'sd0;
            3: v = $signed($urandom);
            default: v = $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        endcase
        return v;
    endfunction

    function automatic t_in_word random_pose(input logic [7:0] area);
        t_in_word w;
        int m;
        m = $urandom_range(0, 19);
        w.target_eye_x = rand_q(m < 2 ? m : (m < 5 ? 3 : 4));
        w.target_eye_y = rand_q($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 4);
        w.target_eye_z = rand_q($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 4);
        w.forward_x    = rand_q($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 4);
        w.forward_y    = rand_q($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 4);
        w.forward_z    = rand_q($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 4);
        if ($urandom_range(0, 15) == 0) begin
            // Short forward vector, below the length threshold or just above it.
            w.forward_x = $signed($urandom_range(0, 80)) - 32'sd40;
            w.forward_y = $signed($urandom_range(0, 80)) - 32'sd40;
            w.forward_z = $signed($urandom_range(0, 80)) - 32'sd40;
        end
        w.pose_valid  = ($urandom_range(0, 9) != 0);
        w.area_number = area;
        case ($urandom_range(0, 9))
            0: w.time_step = 16'd0;
            1: w.time_step = 16'hffff;
            2: w.time_step = 16'($urandom);
            default: w.time_step = 16'($urandom_range(200, 3000));
        endcase
        return w;
    endfunction
endpackage

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import cpsd_pkg::*;
    import cpsd_tb_pkg::*;

    localparam int LATENCY   = 400;
    localparam int N_RANDOM  = 400;
    localparam int MAX_CYCLE = 1000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   errors;
    longint               cycle;
    bit                   rx_hold;

    cpsd_in_if  in_ch();
    cpsd_out_if out_ch();

    camera_pose_smooth_damp_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycle);
        errors++;
    endtask

    // Predicts the smoothed pose for every accepted word and holds the queue of
    // words still owed by the block.
    class pose_smoother;
        logic signed [31:0] eye_pos [3];
        logic signed [31:0] look_pos[3];
        logic signed [31:0] eye_vel [3];
        logic signed [31:0] look_vel[3];
        bit                 started;
        logic [8:0]         last_area;
        logic [24:0]        blend_left;
        logic [23:0]        smooth_reg;
        logic [23:0]        blend_smooth_reg;
        logic [23:0]        blend_dur_reg;
        t_out_word          owed[$];

        function new();
            for (int i = 0; i < 3; i++) begin
                eye_pos[i] = 0; look_pos[i] = 0; eye_vel[i] = 0; look_vel[i] = 0;
            end
            started = 0;
            last_area = 9'd511;
            blend_left = '0;
            smooth_reg = SMOOTH_RST;
            blend_smooth_reg = BLEND_SMOOTH_RST;
            blend_dur_reg = BLEND_DUR_RST;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] v);
            case (idx)
                CFG_SMOOTH:       smooth_reg = v;
                CFG_BLEND_SMOOTH: blend_smooth_reg = v;
                CFG_BLEND_DUR:    blend_dur_reg = v;
                default: ;
            endcase
        endfunction

        // Magnitude product shifted down by 16, capped at 2^62.
        static function logic [63:0] mul_mag(input logic [63:0] a, input logic [63:0] b);
            logic [127:0] p;
            logic [127:0] r;
            p = a * b;
            r = p >> 16;
            return (r > 128'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : r[63:0];
        endfunction

        static function longint mul_s(input longint a, input longint b);
            logic [63:0] ma;
            logic [63:0] mb;
            longint      r;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            r  = longint'(mul_mag(ma, mb));
            return ((a < 0) != (b < 0)) ? -r : r;
        endfunction

        static function longint clip62(input longint v);
            longint cap;
            cap = 64'sh4000_0000_0000_0000;
            return (v > cap) ? cap : ((v < -cap) ? -cap : v);
        endfunction

        static function logic signed [31:0] clip32(input longint v);
            if (v > 64'sh7fff_ffff) return 32'sh7fff_ffff;
            if (v < -64'sh8000_0000) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        static function void spring(inout logic signed [31:0] pos, inout logic signed [31:0] vel,
                                    input longint target, input longint omega,
                                    input longint dt, input longint e);
            longint change;
            longint tmp;
            longint nv;
            longint np;
            change = clip62(longint'(pos) - target);
            tmp = mul_s(clip62(longint'(vel) + mul_s(change, omega)), dt);
            nv  = mul_s(clip62(longint'(vel) - mul_s(tmp, omega)), e);
            np  = clip62(target + mul_s(clip62(change + tmp), e));
            vel = clip32(nv);
            pos = clip32(np);
        endfunction

        function void note_input(input t_in_word w);
            longint      eye[3];
            longint      fwd[3];
            longint      at[3];
            logic [65:0] lensq;
            logic [63:0] st;
            logic [63:0] omega;
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] x3;
            logic [63:0] den;
            logic [63:0] e;
            t_out_word   r;
            eye[0] = w.target_eye_x; eye[1] = w.target_eye_y; eye[2] = w.target_eye_z;
            fwd[0] = w.forward_x; fwd[1] = w.forward_y; fwd[2] = w.forward_z;
            lensq = 0;
            for (int i = 0; i < 3; i++) begin
                lensq += 66'(fwd[i] * fwd[i]);
            end
            if (!w.pose_valid || lensq < 66'd4295) begin
                for (int i = 0; i < 3; i++) begin
                    eye[i] = started ? longint'(eye_pos[i]) : 0;
                    fwd[i] = 0;
                    eye_vel[i] = 0;
                    look_vel[i] = 0;
                end
                if (!started) begin
                    eye[1] = 3 * 65536;
                    eye[2] = -10 * 65536;
                end
                fwd[2] = 65536;
            end
            for (int i = 0; i < 3; i++) at[i] = longint'(clip32(eye[i] + fwd[i]));
            if (!started) begin
                for (int i = 0; i < 3; i++) begin
                    eye_pos[i] = 32'(eye[i]);
                    look_pos[i] = 32'(at[i]);
                end
                started = 1;
            end
            if ({1'b0, w.area_number} != last_area) begin
                blend_left = 25'(blend_dur_reg);
                last_area = {1'b0, w.area_number};
            end
            st = 64'(smooth_reg);
            if (blend_left > 0) begin
                blend_left = (blend_left > 25'(w.time_step)) ?
                             blend_left - 25'(w.time_step) : 25'd0;
                st = 64'(blend_smooth_reg);
            end
            if (st < 64'd7) st = 64'd7;
            omega = (64'd1 << 33) / st;
            x = mul_mag(omega, 64'(w.time_step));
            if (x > 64'h100_0000) x = 64'h100_0000;
            x2 = mul_mag(x, x);
            x3 = mul_mag(x2, x);
            den = 64'd65536 + x + mul_mag(64'd31457, x2) + mul_mag(64'd15401, x3);
            e = (64'd1 << 32) / den;
            for (int i = 0; i < 3; i++) begin
                spring(eye_pos[i], eye_vel[i], eye[i], longint'(omega),
                       longint'(w.time_step), longint'(e));
                spring(look_pos[i], look_vel[i], at[i], longint'(omega),
                       longint'(w.time_step), longint'(e));
            end
            r.eye_x = eye_pos[0]; r.eye_y = eye_pos[1]; r.eye_z = eye_pos[2];
            r.look_at_x = look_pos[0]; r.look_at_y = look_pos[1]; r.look_at_z = look_pos[2];
            owed = {owed, r};
        endfunction

        task check_result(input t_out_word got);
            t_out_word want;
            if (owed.size() == 0) begin
                report("unexpected word", got.eye_x, 32'd0);
                return;
            end
            want = owed.pop_front();
            if (got.eye_x !== want.eye_x) report("eye_x", got.eye_x, want.eye_x);
            if (got.eye_y !== want.eye_y) report("eye_y", got.eye_y, want.eye_y);
            if (got.eye_z !== want.eye_z) report("eye_z", got.eye_z, want.eye_z);
            if (got.look_at_x !== want.look_at_x) report("look_at_x", got.look_at_x, want.look_at_x);
            if (got.look_at_y !== want.look_at_y) report("look_at_y", got.look_at_y, want.look_at_y);
            if (got.look_at_z !== want.look_at_z) report("look_at_z", got.look_at_z, want.look_at_z);
        endtask
    endclass

    pose_smoother smoother;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        smoother = new();
        errors = 0;
        cycle = 0;
        rx_hold = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SMOOTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Checks every word taken at the output.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) smoother.check_result(out_ch.data);
    end

    // Output side: random stalls and, once, a long hold-off.
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                out_ch.ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
                rx_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_word(input t_in_word w, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        smoother.note_input(w);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (smoother.owed.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        smoother.set_reg(idx, v);
    endtask

    initial begin
        t_in_word    w;
        logic [7:0]  area;
        logic [23:0] st_set[5];
        st_set = '{24'd7, 24'd0, 24'd19661, 24'hff_ffff, 24'd3000};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: invalid first pose, extremes, short forward, zero and full step.
        w = '0;
        w.time_step = 16'd1000;
        send_word(w, 0);
        w.pose_valid = 1'b1;
        w.target_eye_x = 32'sh7fff_ffff; w.target_eye_y = 32'sh8000_0000;
        w.target_eye_z = 32'sh7fff_ffff; w.forward_x = 32'sh7fff_ffff;
        w.forward_y = 32'sh8000_0000; w.forward_z = 32'sh8000_0000;
        w.area_number = 8'hff; w.time_step = 16'hffff;
        send_word(w, 0);
        w.time_step = 16'd0;
        send_word(w, 0);
        w.forward_x = 32'sd37; w.forward_y = 32'sd0; w.forward_z = 32'sd0;
        w.area_number = 8'h00; w.time_step = 16'd500;
        send_word(w, 0);
        w.forward_x = 32'sd66; w.target_eye_x = 32'sh8000_0000;
        send_word(w, 0);
        for (int i = 0; i < 12; i++) begin
            w = random_pose(8'(i % 3));
            send_word(w, 0);
        end
        drain();

        write_reg(CFG_SMOOTH, 24'd7);
        write_reg(CFG_BLEND_SMOOTH, 24'hff_ffff);
        write_reg(CFG_BLEND_DUR, 24'd0);
        area = 8'd0;
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_SMOOTH, st_set[ph]);
                write_reg(CFG_BLEND_SMOOTH, st_set[(ph + 2) % 5]);
                write_reg(CFG_BLEND_DUR, (ph == 4) ? 24'hff_ffff : 24'($urandom_range(0, 70000)));
            end
            if (ph == 2) rx_hold = 1;
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                // Areas mostly stay put so the blend timer runs out as well.
                if ($urandom_range(0, 9) == 0) area = 8'($urandom);
                send_word(random_pose(area), (ph == 2) || (i % 20 < 4));
            end
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
